### rtl/obgf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the open-boundary Green function fill block.
package obgf_pkg;

    // Width of a scaled coordinate: a 7-bit index times a 32-bit cell size.
    localparam int XW = 39;
    // Width of x^2 + y^2 in Q.48.
    localparam int XY2W = 79;
    // Quotient width of the 1/(4*pi*r) divide.
    localparam int QW = 45;
    // Width of a Green value.
    localparam int GW = 48;

    localparam logic [QW-1:0] INV4PI_Q48 = 45'd22399066950062;
    localparam logic [GW-1:0] SELF_Q48 = 48'd191452175170000;
    localparam logic [GW-1:0] GREEN_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [6:0] MAX_HALF_POINTS = 7'd64;

    // Configuration register indexes.
    localparam logic [2:0] REG_POINTS_X = 3'd0;
    localparam logic [2:0] REG_POINTS_Y = 3'd1;
    localparam logic [2:0] REG_POINTS_Z = 3'd2;
    localparam logic [2:0] REG_CELL_X = 3'd3;
    localparam logic [2:0] REG_CELL_Y = 3'd4;
    localparam logic [2:0] REG_CELL_Z = 3'd5;
    localparam logic [2:0] REG_Z_PERIOD = 3'd6;
    localparam logic [2:0] REG_PERIODIC_Z = 3'd7;

    // Output slots that use the mirrored address along each axis.
    localparam logic [7:0] SLOT_MIRROR_X = 8'b0001_1110;
    localparam logic [7:0] SLOT_MIRROR_Y = 8'b0110_1100;
    localparam logic [7:0] SLOT_MIRROR_Z = 8'b1101_1000;

    // Tag that travels with each term through the root and divide pipeline.
    typedef struct packed {
        logic [6:0] ix;
        logic [6:0] iy;
        logic [6:0] iz;
        logic       first;
        logic       last;
    } term_tag_t;

endpackage

### rtl/obgf_self_unit.sv
`timescale 1ns / 1ps
// Sequential unit that computes the self term from the cell sizes.
module obgf_self_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [31:0]                cell_x,
    input  logic [31:0]                cell_y,
    input  logic [31:0]                cell_z,
    output logic                       busy,
    output logic [obgf_pkg::GW-1:0]    self_value
);

    typedef enum logic [3:0] {
        SU_IDLE = 4'b0001,
        SU_MUL  = 4'b0010,
        SU_ROOT = 4'b0100,
        SU_DIV  = 4'b1000
    } su_state_t;

    su_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic [65:0] acc_reg, acc_next;
    logic [32:0] root_reg, root_next;
    logic [34:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [obgf_pkg::GW-1:0] value_reg, value_next;

    logic [31:0] sel;
    logic [36:0] rcur;
    logic [36:0] rtrial;
    logic        rge;
    logic [34:0] dcur;
    logic        dge;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: sel = cell_x;
            2'd1: sel = cell_y;
            2'd2: sel = cell_z;
            default: sel = cell_z;
        endcase
        rcur = {rem_reg, acc_reg[65:64]};
        rtrial = {2'b00, root_reg, 2'b01};
        rge = rcur >= rtrial;
        dcur = {rem_reg[33:0], obgf_pkg::SELF_Q48[cnt_reg]};
        dge = dcur >= {2'b00, root_reg};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        root_next = root_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        value_next = value_reg;
        unique case (state_reg)
            SU_IDLE: begin
            end
            SU_MUL: begin
                prod_next = sel * sel;
                if (cnt_reg == 6'd0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + {2'b00, prod_reg};
                end
                if (cnt_reg == 6'd3) begin
                    state_next = SU_ROOT;
                    cnt_next = 6'd32;
                    rem_next = '0;
                    root_next = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            SU_ROOT: begin
                rem_next = rge ? 35'(rcur - rtrial) : 35'(rcur);
                root_next = {root_reg[31:0], rge};
                acc_next = {acc_reg[63:0], 2'b00};
                if (cnt_reg == 6'd0) begin
                    state_next = SU_DIV;
                    cnt_next = 6'd47;
                    rem_next = '0;
                    quo_next = '0;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            SU_DIV: begin
                rem_next = dge ? (dcur - {2'b00, root_reg}) : dcur;
                quo_next = {quo_reg[46:0], dge};
                if (cnt_reg == 6'd0) begin
                    // A zero cell diagonal saturates the self term.
                    value_next = (root_reg == 33'd0) ? obgf_pkg::GREEN_MAX
                                                     : {quo_reg[46:0], dge};
                    state_next = SU_IDLE;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            default: begin
                state_next = SU_IDLE;
            end
        endcase
        if (start) begin
            state_next = SU_MUL;
            cnt_next = 6'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_MUL;
            cnt_reg <= 6'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        root_reg <= root_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        value_reg <= value_next;
    end

    assign busy = (state_reg != SU_IDLE);
    assign self_value = value_reg;

endmodule

### rtl/obgf_term_pipe.sv
`timescale 1ns / 1ps
// Pipelined term unit: r2 = xy2 + zt^2, r = isqrt(r2), quotient INV4PI_Q48 / r.
module obgf_term_pipe #(
    parameter int ZTW = 40
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        in_valid,
    input  obgf_pkg::term_tag_t         in_tag,
    input  logic [obgf_pkg::XY2W-1:0]   in_xy2,
    input  logic [ZTW-1:0]              in_zt,
    output logic                        out_valid,
    output obgf_pkg::term_tag_t         out_tag,
    output logic                        out_zero,
    output logic [obgf_pkg::QW-1:0]     out_quot
);

    localparam int ZHW = ZTW - 32;
    localparam int R2W = 2 * ZTW + 1;
    localparam int RW = (R2W + 1) / 2;
    localparam int NW = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int CURW = REMW + 2;
    localparam int DREMW = RW + 1;
    localparam int QW = obgf_pkg::QW;

    // Square of the z coordinate, split into partial products.
    logic                        s1_valid_reg;
    obgf_pkg::term_tag_t         s1_tag_reg;
    logic                        s1_zero_reg;
    logic [obgf_pkg::XY2W-1:0]   s1_xy2_reg;
    logic [63:0]                 s1_zl2_reg;
    logic [ZHW+31:0]             s1_zm_reg;
    logic [2*ZHW-1:0]            s1_zh2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_tag_reg <= in_tag;
            s1_zero_reg <= (in_xy2 == '0) && (in_zt == '0);
            s1_xy2_reg <= in_xy2;
            s1_zl2_reg <= in_zt[31:0] * in_zt[31:0];
            s1_zm_reg <= in_zt[ZTW-1:32] * in_zt[31:0];
            s1_zh2_reg <= in_zt[ZTW-1:32] * in_zt[ZTW-1:32];
        end
    end

    // Square root, one result bit per stage. Stage 0 holds r2.
    logic                        sq_valid_reg [0:RW];
    obgf_pkg::term_tag_t         sq_tag_reg [0:RW];
    logic                        sq_zero_reg [0:RW];
    logic [NW-1:0]               sq_n_reg [0:RW];
    logic [REMW-1:0]             sq_rem_reg [0:RW];
    logic [RW-1:0]               sq_root_reg [0:RW];

    logic [R2W-1:0] r2_sum;

    assign r2_sum = R2W'(s1_xy2_reg) + R2W'(s1_zl2_reg) + (R2W'(s1_zm_reg) << 33)
                  + (R2W'(s1_zh2_reg) << 64);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_tag_reg[0] <= s1_tag_reg;
            sq_zero_reg[0] <= s1_zero_reg;
            sq_n_reg[0] <= NW'(r2_sum);
            sq_rem_reg[0] <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < RW; s++) begin : g_root
        logic [CURW-1:0] cur;
        logic [CURW-1:0] trial;
        logic            ge;
        logic [REMW-1:0] rem_next;
        logic [RW-1:0]   root_next;

        always_comb begin
            cur = {sq_rem_reg[s], sq_n_reg[s][NW-1-2*s -: 2]};
            trial = CURW'({sq_root_reg[s], 2'b01});
            ge = cur >= trial;
            rem_next = ge ? REMW'(cur - trial) : REMW'(cur);
            root_next = {sq_root_reg[s][RW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[s+1] <= 1'b0;
            end else if (advance) begin
                sq_valid_reg[s+1] <= sq_valid_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                sq_tag_reg[s+1] <= sq_tag_reg[s];
                sq_zero_reg[s+1] <= sq_zero_reg[s];
                sq_n_reg[s+1] <= sq_n_reg[s];
                sq_rem_reg[s+1] <= rem_next;
                sq_root_reg[s+1] <= root_next;
            end
        end
    end

    // Restoring divide of a constant numerator, one quotient bit per stage.
    logic                        dv_valid_reg [0:QW];
    obgf_pkg::term_tag_t         dv_tag_reg [0:QW];
    logic                        dv_zero_reg [0:QW];
    logic [RW-1:0]               dv_div_reg [0:QW];
    logic [DREMW-1:0]            dv_rem_reg [0:QW];
    logic [QW-1:0]               dv_q_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            dv_valid_reg[0] <= sq_valid_reg[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dv_tag_reg[0] <= sq_tag_reg[RW];
            dv_zero_reg[0] <= sq_zero_reg[RW];
            dv_div_reg[0] <= sq_root_reg[RW];
            dv_rem_reg[0] <= '0;
            dv_q_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [DREMW:0]   cur;
        logic             ge;
        logic [DREMW-1:0] rem_next;

        always_comb begin
            cur = {dv_rem_reg[s], obgf_pkg::INV4PI_Q48[QW-1-s]};
            ge = cur >= (DREMW+1)'(dv_div_reg[s]);
            rem_next = ge ? DREMW'(cur - (DREMW+1)'(dv_div_reg[s])) : DREMW'(cur);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[s+1] <= 1'b0;
            end else if (advance) begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                dv_tag_reg[s+1] <= dv_tag_reg[s];
                dv_zero_reg[s+1] <= dv_zero_reg[s];
                dv_div_reg[s+1] <= dv_div_reg[s];
                dv_rem_reg[s+1] <= rem_next;
                dv_q_reg[s+1] <= {dv_q_reg[s][QW-2:0], ge};
            end
        end
    end

    assign out_valid = dv_valid_reg[QW];
    assign out_tag = dv_tag_reg[QW];
    assign out_zero = dv_zero_reg[QW];
    assign out_quot = dv_q_reg[QW];

endmodule

### rtl/open_boundary_green_function_fill.sv
`timescale 1ns / 1ps
// Top level of the open-boundary Green function fill block.
// Each grid point word passes four front stages that form x^2 + y^2, then an
// issue stage that sends its terms, one per cycle while the pipeline is not
// stalled, into a shared pipeline that squares z, takes the integer square
// root one bit per stage and divides one quotient bit per stage. A point has
// one term without z images and 2*IMAGE_COUNT+1 terms with them (nine at the
// default), and its up to eight result words leave the emitter one per cycle
// while m_ready is high; the emitter runs in parallel with the next point, so
// the slower of the two sets the rate. The root is RW bits wide, half the
// width of the squared distance (41 at the default). After reset and after
// every write of a cell size the self term is recomputed by a sequential unit,
// during which no point is accepted.
module open_boundary_green_function_fill #(
    parameter int IMAGE_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_index_x,
    input  logic [6:0]  s_index_y,
    input  logic [6:0]  s_index_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_addr_x,
    output logic [6:0]  m_addr_y,
    output logic [6:0]  m_addr_z,
    output logic [47:0] m_green_value,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int XW = obgf_pkg::XW;
    localparam int GW = obgf_pkg::GW;
    localparam int TW = $clog2(2 * IMAGE_COUNT + 1);
    localparam int DW = 32 + $clog2(IMAGE_COUNT + 1);
    localparam int ZTW = ((DW > XW) ? DW : XW) + 1;
    localparam logic [TW-1:0] LAST_TERM = TW'(2 * IMAGE_COUNT);

    function automatic logic [6:0] clamp_points(input logic [6:0] n);
        return (n > obgf_pkg::MAX_HALF_POINTS) ? obgf_pkg::MAX_HALF_POINTS : n;
    endfunction

    function automatic logic [6:0] mirror(input logic [6:0] n, input logic [6:0] i);
        logic [7:0] d;
        d = {n, 1'b0} - {1'b0, i};
        return d[6:0];
    endfunction

    // Configuration registers.
    logic [6:0]  points_x_reg, points_y_reg, points_z_reg;
    logic [31:0] cell_x_reg, cell_y_reg, cell_z_reg, z_period_reg;
    logic        periodic_z_reg;
    logic        cfg_write;
    logic        self_start;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign self_start = cfg_write && ((cfg_index == obgf_pkg::REG_CELL_X)
                        || (cfg_index == obgf_pkg::REG_CELL_Y)
                        || (cfg_index == obgf_pkg::REG_CELL_Z));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_x_reg <= 7'd32;
            points_y_reg <= 7'd32;
            points_z_reg <= 7'd32;
            cell_x_reg <= 32'd65536;
            cell_y_reg <= 32'd65536;
            cell_z_reg <= 32'd65536;
            z_period_reg <= 32'd2097152;
            periodic_z_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                obgf_pkg::REG_POINTS_X: points_x_reg <= cfg_data[6:0];
                obgf_pkg::REG_POINTS_Y: points_y_reg <= cfg_data[6:0];
                obgf_pkg::REG_POINTS_Z: points_z_reg <= cfg_data[6:0];
                obgf_pkg::REG_CELL_X: cell_x_reg <= cfg_data;
                obgf_pkg::REG_CELL_Y: cell_y_reg <= cfg_data;
                obgf_pkg::REG_CELL_Z: cell_z_reg <= cfg_data;
                obgf_pkg::REG_Z_PERIOD: z_period_reg <= cfg_data;
                obgf_pkg::REG_PERIODIC_Z: periodic_z_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Self term.
    logic          self_busy;
    logic [GW-1:0] self_value;

    obgf_self_unit u_self (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (self_start),
        .cell_x     (cell_x_reg),
        .cell_y     (cell_y_reg),
        .cell_z     (cell_z_reg),
        .busy       (self_busy),
        .self_value (self_value)
    );

    // Global pipeline control.
    logic                  pipe_en;
    logic                  front_adv;
    logic                  iss_valid_reg;
    logic                  iss_last;
    logic                  tp_valid;
    obgf_pkg::term_tag_t   tp_tag;
    logic                  tp_zero;
    logic [obgf_pkg::QW-1:0] tp_quot;
    logic                  emit_free;
    logic                  consume;

    assign consume = tp_valid && (!tp_tag.last || emit_free);
    assign pipe_en = !tp_valid || consume;
    assign front_adv = pipe_en && (!iss_valid_reg || iss_last);
    assign s_ready = front_adv && !self_busy;

    // Front stages: scaled coordinates, partial squares, x^2 and y^2, sum.
    logic              f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    logic [6:0]        f1_ix_reg, f1_iy_reg, f1_iz_reg;
    logic [6:0]        f2_ix_reg, f2_iy_reg, f2_iz_reg;
    logic [6:0]        f3_ix_reg, f3_iy_reg, f3_iz_reg;
    logic [6:0]        f4_ix_reg, f4_iy_reg, f4_iz_reg;
    logic [XW-1:0]     f1_x_reg, f1_y_reg, f1_z_reg;
    logic [XW-1:0]     f2_z_reg, f3_z_reg, f4_z_reg;
    logic [63:0]       f2_xl2_reg, f2_yl2_reg;
    logic [XW-1:0]     f2_xm_reg, f2_ym_reg;
    logic [13:0]       f2_xh2_reg, f2_yh2_reg;
    logic [77:0]       f3_x2_reg, f3_y2_reg;
    logic [obgf_pkg::XY2W-1:0] f4_xy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end else if (front_adv) begin
            f1_valid_reg <= s_valid && s_ready;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_adv) begin
            f1_ix_reg <= s_index_x;
            f1_iy_reg <= s_index_y;
            f1_iz_reg <= s_index_z;
            f1_x_reg <= s_index_x * cell_x_reg;
            f1_y_reg <= s_index_y * cell_y_reg;
            f1_z_reg <= s_index_z * cell_z_reg;

            f2_ix_reg <= f1_ix_reg;
            f2_iy_reg <= f1_iy_reg;
            f2_iz_reg <= f1_iz_reg;
            f2_z_reg <= f1_z_reg;
            f2_xl2_reg <= f1_x_reg[31:0] * f1_x_reg[31:0];
            f2_xm_reg <= f1_x_reg[XW-1:32] * f1_x_reg[31:0];
            f2_xh2_reg <= f1_x_reg[XW-1:32] * f1_x_reg[XW-1:32];
            f2_yl2_reg <= f1_y_reg[31:0] * f1_y_reg[31:0];
            f2_ym_reg <= f1_y_reg[XW-1:32] * f1_y_reg[31:0];
            f2_yh2_reg <= f1_y_reg[XW-1:32] * f1_y_reg[XW-1:32];

            f3_ix_reg <= f2_ix_reg;
            f3_iy_reg <= f2_iy_reg;
            f3_iz_reg <= f2_iz_reg;
            f3_z_reg <= f2_z_reg;
            f3_x2_reg <= {14'b0, f2_xl2_reg} + {6'b0, f2_xm_reg, 33'b0}
                       + {f2_xh2_reg, 64'b0};
            f3_y2_reg <= {14'b0, f2_yl2_reg} + {6'b0, f2_ym_reg, 33'b0}
                       + {f2_yh2_reg, 64'b0};

            f4_ix_reg <= f3_ix_reg;
            f4_iy_reg <= f3_iy_reg;
            f4_iz_reg <= f3_iz_reg;
            f4_z_reg <= f3_z_reg;
            f4_xy2_reg <= {1'b0, f3_x2_reg} + {1'b0, f3_y2_reg};
        end
    end

    // Issue stage: holds one point and sends its z images one per cycle while pipe_en is high.
    logic [6:0]                iss_ix_reg, iss_iy_reg, iss_iz_reg;
    logic [obgf_pkg::XY2W-1:0] iss_xy2_reg;
    logic [XW-1:0]             iss_z_reg;
    logic [TW-1:0]             iss_t_reg;
    logic [DW-1:0]             iss_d_reg;
    logic [ZTW-1:0]            z_w, d_w, iss_zt;
    obgf_pkg::term_tag_t       iss_tag;

    assign iss_last = !periodic_z_reg || (iss_t_reg == LAST_TERM);

    always_comb begin
        z_w = ZTW'(iss_z_reg);
        d_w = ZTW'(iss_d_reg);
        if (iss_t_reg == '0) begin
            iss_zt = z_w;
        end else if (iss_t_reg[0]) begin
            iss_zt = z_w + d_w;
        end else begin
            iss_zt = (z_w > d_w) ? (z_w - d_w) : (d_w - z_w);
        end
        iss_tag.ix = iss_ix_reg;
        iss_tag.iy = iss_iy_reg;
        iss_tag.iz = iss_iz_reg;
        iss_tag.first = (iss_t_reg == '0);
        iss_tag.last = iss_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_valid_reg <= 1'b0;
            iss_t_reg <= '0;
        end else if (front_adv) begin
            iss_valid_reg <= f4_valid_reg;
            iss_t_reg <= '0;
        end else if (pipe_en && iss_valid_reg) begin
            iss_t_reg <= iss_t_reg + TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (front_adv) begin
            iss_ix_reg <= f4_ix_reg;
            iss_iy_reg <= f4_iy_reg;
            iss_iz_reg <= f4_iz_reg;
            iss_xy2_reg <= f4_xy2_reg;
            iss_z_reg <= f4_z_reg;
        end
        // The image offset steps by one period after each pair of images.
        if (pipe_en && iss_valid_reg) begin
            if (iss_t_reg == '0) begin
                iss_d_reg <= DW'(z_period_reg);
            end else if (!iss_t_reg[0]) begin
                iss_d_reg <= iss_d_reg + DW'(z_period_reg);
            end
        end
    end

    obgf_term_pipe #(
        .ZTW (ZTW)
    ) u_term (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (pipe_en),
        .in_valid  (iss_valid_reg),
        .in_tag    (iss_tag),
        .in_xy2    (iss_xy2_reg),
        .in_zt     (iss_zt),
        .out_valid (tp_valid),
        .out_tag   (tp_tag),
        .out_zero  (tp_zero),
        .out_quot  (tp_quot)
    );

    // Saturating accumulation of the terms of one point.
    logic [GW-1:0] acc_reg;
    logic [GW-1:0] term_val;
    logic [GW:0]   acc_sum;
    logic [GW-1:0] acc_next;

    always_comb begin
        term_val = tp_zero ? self_value : GW'(tp_quot);
        acc_sum = {1'b0, acc_reg} + {1'b0, term_val};
        if (tp_tag.first) begin
            acc_next = term_val;
        end else begin
            acc_next = acc_sum[GW] ? obgf_pkg::GREEN_MAX : acc_sum[GW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            acc_reg <= acc_next;
        end
    end

    // Emitter: one word per pending mirror slot, lowest slot first.
    logic [7:0]    em_pend_reg;
    logic [GW-1:0] em_g_reg;
    logic [6:0]    em_ix_reg, em_iy_reg, em_iz_reg;
    logic [6:0]    em_mx_reg, em_my_reg, em_mz_reg;
    logic [7:0]    em_rest;
    logic [7:0]    em_slot;
    logic [6:0]    nx, ny, nz;
    logic          vx, vy, vz;
    logic [7:0]    load_mask;
    logic          emit_load;

    always_comb begin
        nx = clamp_points(points_x_reg);
        ny = clamp_points(points_y_reg);
        nz = clamp_points(points_z_reg);
        vx = (tp_tag.ix != 7'd0) && (tp_tag.ix < nx);
        vy = (tp_tag.iy != 7'd0) && (tp_tag.iy < ny);
        vz = (tp_tag.iz != 7'd0) && (tp_tag.iz < nz);
        load_mask = {vz, vy && vz, vy, vx && vz, vx && vy && vz, vx && vy, vx, 1'b1};
        em_rest = em_pend_reg & (em_pend_reg - 8'd1);
        em_slot = em_pend_reg & ~(em_pend_reg - 8'd1);
    end

    assign emit_free = (em_pend_reg == 8'd0) || (m_ready && (em_rest == 8'd0));
    assign emit_load = consume && tp_tag.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_pend_reg <= 8'd0;
        end else if (emit_load) begin
            em_pend_reg <= load_mask;
        end else if (m_valid && m_ready) begin
            em_pend_reg <= em_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            em_g_reg <= acc_next;
            em_ix_reg <= tp_tag.ix;
            em_iy_reg <= tp_tag.iy;
            em_iz_reg <= tp_tag.iz;
            em_mx_reg <= mirror(nx, tp_tag.ix);
            em_my_reg <= mirror(ny, tp_tag.iy);
            em_mz_reg <= mirror(nz, tp_tag.iz);
        end
    end

    assign m_valid = (em_pend_reg != 8'd0);
    assign m_last = (em_rest == 8'd0);
    assign m_green_value = em_g_reg;
    assign m_addr_x = ((em_slot & obgf_pkg::SLOT_MIRROR_X) != 8'd0) ? em_mx_reg : em_ix_reg;
    assign m_addr_y = ((em_slot & obgf_pkg::SLOT_MIRROR_Y) != 8'd0) ? em_my_reg : em_iy_reg;
    assign m_addr_z = ((em_slot & obgf_pkg::SLOT_MIRROR_Z) != 8'd0) ? em_mz_reg : em_iz_reg;

    // No point may enter while the self term is being recomputed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        self_busy |-> !s_ready)
        else $error("point accepted while self term is busy");

    // A freshly loaded point always emits its own address first.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> em_pend_reg[0])
        else $error("emitter loaded without the point itself");

    // A held tail term keeps its quotient while the pipeline is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tp_valid && !pipe_en) |=> (tp_valid && $stable(tp_quot)))
        else $error("term lost during stall");

endmodule
